// ===== hdl/sne_pkg.sv =====
// ----------------------------------------------------------------------------
// sne_pkg - shared constants and types for the Sobel/NMS edge thinning block
// Field widths, register indexes, reset values and direction codes.
// ----------------------------------------------------------------------------
package sne_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 4096;

  localparam int PIX_W      = 8;
  localparam int FW_W       = 11;
  localparam int FH_W       = 13;
  localparam int THR_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_THRESHOLD  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THRESHOLD = 2'd3;

  localparam logic [FW_W-1:0]  RST_FRAME_WIDTH    = 11'd640;
  localparam logic [FH_W-1:0]  RST_FRAME_HEIGHT   = 13'd480;
  localparam logic [THR_W-1:0] RST_LOW_THRESHOLD  = 8'd100;
  localparam logic [THR_W-1:0] RST_HIGH_THRESHOLD = 8'd200;

  localparam logic CMD_PIXEL = 1'b0;

  // tan(22.5) and tan(67.5) in Q8
  localparam int TAN_LO_Q8 = 106;
  localparam int TAN_HI_Q8 = 618;

  typedef enum logic [1:0] {
    DIR_0   = 2'd0,
    DIR_45  = 2'd1,
    DIR_M45 = 2'd2,
    DIR_90  = 2'd3
  } dir_t;

endpackage

// ===== hdl/sne_if.sv =====
// ----------------------------------------------------------------------------
// sne_if - channel interfaces of the Sobel/NMS edge thinning block
// Pixel input stream, edge result stream and configuration write channel.
// ----------------------------------------------------------------------------
interface sne_pix_if;
  import sne_pkg::*;
  logic             valid;
  logic             ready;
  logic             cmd;
  logic [PIX_W-1:0] pixel;
  modport source (output valid, cmd, pixel, input ready);
  modport sink   (input valid, cmd, pixel, output ready);
endinterface

interface sne_edge_if;
  import sne_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] edge_res;
  logic             frame_last;
  modport source (output valid, edge_res, frame_last, input ready);
  modport sink   (input valid, edge_res, frame_last, output ready);
endinterface

interface sne_cfg_if;
  import sne_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/sne_ram.sv =====
// ----------------------------------------------------------------------------
// sne_ram - generic single-clock RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sne_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/sobel_nms_edge_thinning.sv =====
// ----------------------------------------------------------------------------
// sobel_nms_edge_thinning - Sobel gradient, non-maximum suppression and
// double threshold over a raster-ordered grayscale pixel stream
// ----------------------------------------------------------------------------
// Usage:
//   pixels: cmd 0 carries a pixel in raster order; cmd 1 is a drain tick that
//   pushes out one pending result after the last pixel of a frame. A drain
//   tick with nothing pending is taken and dropped.
//   edges: one result per pixel, raster order, frame_last on the final one.
//   The result of pixel q is released by pixel q + 2W + 2, the last 2W + 2
//   results of a frame by drain ticks.
//   cfg: register writes, always ready. Write geometry only while idle; a
//   geometry write restarts the frame.
// Throughput: one transaction per clock on every channel while edges is not
//   held off. From the releasing input transaction the result runs through
//   a pixel line RAM, the Sobel adder, the magnitude/direction unit and a
//   magnitude line RAM; both RAMs have registered read data. Both line RAMs
//   hold two rows addressed by column.
// Reset: registers return to 640x480, thresholds 100/200, frame restarts.
//   The line RAMs are not cleared; border masking hides unwritten rows.
// Stall: when edges is held off, the whole pipeline freezes and pixels.ready
//   drops; the output register holds its result until taken.
// ----------------------------------------------------------------------------
module sobel_nms_edge_thinning #(
  parameter int MAX_WIDTH  = sne_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = sne_pkg::DEF_MAX_HEIGHT
) (
  input  logic        clk,
  input  logic        rst,
  sne_pix_if.sink     pixels,
  sne_edge_if.source  edges,
  sne_cfg_if.sink     cfg
);

  import sne_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  typedef struct packed {
    logic          emit;
    logic          border;
    logic          last;
    logic [CW-1:0] x;
  } ctl_t;

  typedef struct packed {
    logic top;
    logic bot;
    logic left;
    logic right;
  } msk_t;

  // configuration
  logic [FW_W-1:0]  frame_width;
  logic [FH_W-1:0]  frame_height;
  logic [THR_W-1:0] low_threshold;
  logic [THR_W-1:0] high_threshold;

  logic [CW:0]   w_eff;
  logic [RW:0]   h_eff;
  logic [CW-1:0] wm1;
  logic [RW-1:0] hm1;

  // positions
  logic [RW:0]   sr;
  logic [CW-1:0] sc;
  logic [RW-1:0] out_row;
  logic [CW-1:0] out_col;

  logic          is_pix, frame_done, draining, restart, geo_wr;
  logic          adv, accept, step, emit;
  logic [RW:0]   cur_r, sr_next;
  logic [CW-1:0] cur_c, sc_next;
  logic [RW-1:0] o_r, out_row_next;
  logic [CW-1:0] o_c, out_col_next;
  logic          c_wrap, oc_last, or_last;
  ctl_t          ctl0;
  msk_t          msk0;

  // pipeline
  logic                v1, v2, v3, v4, v5;
  ctl_t                ctl1, ctl2, ctl3, ctl4, ctl5;
  msk_t                msk1, msk2;
  logic [PIX_W-1:0]    pix1;
  logic [2*PIX_W-1:0]  prd;
  logic [PIX_W-1:0]    pw [3][3];
  logic [PIX_W-1:0]    tp [3][3];
  logic [10:0]         gx_pos, gx_neg, gy_pos, gy_neg;
  logic signed [11:0]  gx, gy, gx3, gy3;
  logic [11:0]         ax, ay;
  logic [PIX_W-1:0]    cx, cy;
  logic [PIX_W:0]      msum;
  logic [PIX_W-1:0]    mag;
  logic signed [11:0]  dir_a;
  logic signed [21:0]  ha, hi, lo;
  dir_t                dir;
  logic [PIX_W-1:0]    m4n;
  dir_t                d4n;
  logic [2*PIX_W+1:0]  mrd;
  logic [PIX_W-1:0]    mw [3][3];
  dir_t                dw_c, dw_n;
  logic [PIX_W-1:0]    mc, n1, n2, thin, res5;

  // effective geometry
  always_comb begin
    if (32'(frame_width) < 32'd3) begin
      w_eff = (CW+1)'(3);
    end else if (32'(frame_width) > 32'(MAX_WIDTH)) begin
      w_eff = (CW+1)'(MAX_WIDTH);
    end else begin
      w_eff = (CW+1)'(frame_width);
    end
    if (32'(frame_height) < 32'd3) begin
      h_eff = (RW+1)'(3);
    end else if (32'(frame_height) > 32'(MAX_HEIGHT)) begin
      h_eff = (RW+1)'(MAX_HEIGHT);
    end else begin
      h_eff = (RW+1)'(frame_height);
    end
    wm1 = CW'(w_eff - 1'b1);
    hm1 = RW'(h_eff - 1'b1);
  end

  // step control
  always_comb begin
    is_pix     = pixels.cmd == CMD_PIXEL;
    frame_done = sr >= h_eff;
    draining   = frame_done && (out_row != '0 || out_col != '0);
    restart    = is_pix && frame_done;
    adv        = !edges.valid || edges.ready;
    accept     = pixels.valid && adv;
    step       = accept && (is_pix || draining);
    geo_wr     = cfg.valid &&
                 (cfg.index == CFG_FRAME_WIDTH || cfg.index == CFG_FRAME_HEIGHT);

    cur_r = restart ? '0 : sr;
    cur_c = restart ? '0 : sc;
    o_r   = restart ? '0 : out_row;
    o_c   = restart ? '0 : out_col;

    emit = is_pix ? (cur_r > (RW+1)'(2) || (cur_r == (RW+1)'(2) && cur_c >= CW'(2)))
                  : 1'b1;

    c_wrap  = cur_c == wm1;
    sc_next = c_wrap ? '0 : cur_c + 1'b1;
    sr_next = c_wrap ? cur_r + 1'b1 : cur_r;

    oc_last      = o_c == wm1;
    or_last      = o_r == hm1;
    out_col_next = oc_last ? '0 : o_c + 1'b1;
    out_row_next = oc_last ? (or_last ? '0 : o_r + 1'b1) : o_r;

    // Sobel center sits one row and one column behind the incoming tap
    msk0.top   = (cur_c != '0) ? (cur_r == (RW+1)'(1)) : (cur_r == (RW+1)'(2));
    msk0.bot   = (cur_c != '0) ? (cur_r == h_eff) : (cur_r == h_eff + 1'b1);
    msk0.left  = cur_c == CW'(1);
    msk0.right = cur_c == '0;

    ctl0.emit   = emit;
    ctl0.border = o_r == '0 || o_c == '0 || or_last || oc_last;
    ctl0.last   = or_last && oc_last;
    ctl0.x      = cur_c;
  end

  assign pixels.ready = adv;
  assign cfg.ready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width    <= RST_FRAME_WIDTH;
      frame_height   <= RST_FRAME_HEIGHT;
      low_threshold  <= RST_LOW_THRESHOLD;
      high_threshold <= RST_HIGH_THRESHOLD;
      sr             <= '0;
      sc             <= '0;
      out_row        <= '0;
      out_col        <= '0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.index)
          CFG_FRAME_WIDTH:    frame_width    <= cfg.data[FW_W-1:0];
          CFG_FRAME_HEIGHT:   frame_height   <= cfg.data[FH_W-1:0];
          CFG_LOW_THRESHOLD:  low_threshold  <= cfg.data[THR_W-1:0];
          CFG_HIGH_THRESHOLD: high_threshold <= cfg.data[THR_W-1:0];
          default: ;
        endcase
      end
      // a geometry write restarts the frame
      if (geo_wr) begin
        sr      <= '0;
        sc      <= '0;
        out_row <= '0;
        out_col <= '0;
      end else if (step) begin
        sr      <= sr_next;
        sc      <= sc_next;
        out_row <= emit ? out_row_next : o_r;
        out_col <= emit ? out_col_next : o_c;
      end
    end
  end

  // pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (adv) begin
      v1 <= step;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  // pixel line RAM: {row - 2, row - 1} at each column
  sne_ram #(
    .WIDTH (2*PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_pix_ram (
    .clk   (clk),
    .we    (adv && v1),
    .waddr (ctl1.x),
    .wdata ({prd[PIX_W-1:0], pix1}),
    .re    (adv),
    .raddr (cur_c),
    .rdata (prd)
  );

  // magnitude line RAM: {mag row - 2, mag row - 1, dir row - 1}
  sne_ram #(
    .WIDTH (2*PIX_W+2),
    .DEPTH (MAX_WIDTH)
  ) u_mag_ram (
    .clk   (clk),
    .we    (adv && v4),
    .waddr (ctl4.x),
    .wdata ({mrd[PIX_W+1:2], m4n, d4n}),
    .re    (adv),
    .raddr (ctl3.x),
    .rdata (mrd)
  );

  // Sobel on the masked window
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if ((r == 0 && msk2.top) || (r == 2 && msk2.bot) ||
            (c == 0 && msk2.left) || (c == 2 && msk2.right)) begin
          tp[r][c] = '0;
        end else begin
          tp[r][c] = pw[r][c];
        end
      end
    end
    gx_pos = {3'b0, tp[0][2]} + {2'b0, tp[1][2], 1'b0} + {3'b0, tp[2][2]};
    gx_neg = {3'b0, tp[0][0]} + {2'b0, tp[1][0], 1'b0} + {3'b0, tp[2][0]};
    gy_pos = {3'b0, tp[2][0]} + {2'b0, tp[2][1], 1'b0} + {3'b0, tp[2][2]};
    gy_neg = {3'b0, tp[0][0]} + {2'b0, tp[0][1], 1'b0} + {3'b0, tp[0][2]};
    gx = $signed({1'b0, gx_pos}) - $signed({1'b0, gx_neg});
    gy = $signed({1'b0, gy_pos}) - $signed({1'b0, gy_neg});
  end

  // magnitude and quantized direction
  always_comb begin
    ax   = gx3[11] ? 12'(-gx3) : 12'(gx3);
    ay   = gy3[11] ? 12'(-gy3) : 12'(gy3);
    cx   = (ax > 12'd255) ? '1 : ax[PIX_W-1:0];
    cy   = (ay > 12'd255) ? '1 : ay[PIX_W-1:0];
    msum = {1'b0, cx} + {1'b0, cy};
    mag  = msum[PIX_W:1];

    dir_a = gx3[11] ? -gy3 : gy3;
    ha    = $signed({{2{dir_a[11]}}, dir_a, 8'b0});
    hi    = $signed(22'(ax) * 22'(TAN_HI_Q8));
    lo    = $signed(22'(ax) * 22'(TAN_LO_Q8));
    if (gx3 == '0) begin
      dir = (gy3 == '0) ? DIR_0 : DIR_90;
    end else if (ha >= hi || ha < -hi) begin
      dir = DIR_90;
    end else if (ha >= lo) begin
      dir = DIR_45;
    end else if (ha >= -lo) begin
      dir = DIR_0;
    end else begin
      dir = DIR_M45;
    end
  end

  // non-maximum suppression and double threshold
  always_comb begin
    mc = mw[1][1];
    case (dw_c)
      DIR_0: begin
        n1 = mw[1][0];
        n2 = mw[1][2];
      end
      DIR_45: begin
        n1 = mw[0][0];
        n2 = mw[2][2];
      end
      DIR_M45: begin
        n1 = mw[2][0];
        n2 = mw[0][2];
      end
      default: begin
        n1 = mw[0][1];
        n2 = mw[2][1];
      end
    endcase
    thin = (mc < n1 || mc < n2) ? '0 : mc;
    if (ctl5.border) begin
      res5 = '0;
    end else if (thin > high_threshold) begin
      res5 = '1;
    end else if (thin < low_threshold) begin
      res5 = '0;
    end else begin
      res5 = thin;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (adv) begin
      pix1 <= pixels.pixel;
      ctl1 <= ctl0;
      msk1 <= msk0;

      if (v1) begin
        for (int r = 0; r < 3; r++) begin
          pw[r][0] <= pw[r][1];
          pw[r][1] <= pw[r][2];
        end
        pw[0][2] <= prd[2*PIX_W-1:PIX_W];
        pw[1][2] <= prd[PIX_W-1:0];
        pw[2][2] <= pix1;
      end
      ctl2 <= ctl1;
      msk2 <= msk1;

      gx3  <= gx;
      gy3  <= gy;
      ctl3 <= ctl2;

      m4n  <= mag;
      d4n  <= dir;
      ctl4 <= ctl3;

      if (v4) begin
        for (int r = 0; r < 3; r++) begin
          mw[r][0] <= mw[r][1];
          mw[r][1] <= mw[r][2];
        end
        mw[0][2] <= mrd[2*PIX_W+1:PIX_W+2];
        mw[1][2] <= mrd[PIX_W+1:2];
        mw[2][2] <= m4n;
        dw_c     <= dw_n;
        dw_n     <= dir_t'(mrd[1:0]);
      end
      ctl5 <= ctl4;

      edges.edge_res   <= res5;
      edges.frame_last <= ctl5.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      edges.valid <= 1'b0;
    end else if (adv) begin
      edges.valid <= v5 && ctl5.emit;
    end
  end

endmodule

// ===== hdl/sne_checker.sv =====
// ----------------------------------------------------------------------------
// sne_checker - port-level checks for sobel_nms_edge_thinning
// Output hold, reset, frame-end border value and pipeline readiness.
// ----------------------------------------------------------------------------
module sne_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [sne_pkg::PIX_W-1:0] edge_res,
  input logic                      frame_last
);

  import sne_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(edge_res) && $stable(frame_last))
    else $error("stalled result changed");

  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // the last pixel of a frame is a corner, so it is always zero
  a_last_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_last |-> edge_res == '0)
    else $error("frame end result not zero");

  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input held off with empty output");

endmodule

bind sobel_nms_edge_thinning sne_checker u_sne_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (pixels.ready),
  .out_valid  (edges.valid),
  .out_ready  (edges.ready),
  .edge_res   (edges.edge_res),
  .frame_last (edges.frame_last)
);
